// ===== hdl/mrpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpq_pkg
// Types, constants and helpers shared by the radix priority queue modules.
// ----------------------------------------------------------------------------
package mrpq_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 16;
    localparam int CAPACITY   = 1024;
    localparam int NB         = KEY_BITS + 1;
    localparam int BW         = $clog2(NB);
    localparam int AW         = $clog2(CAPACITY);
    localparam int CW         = $clog2(CAPACITY + 1);

    localparam logic REQ_POP = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BELOW  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef struct packed {
        logic                  req_type;
        logic [KEY_BITS-1:0]   push_key;
        logic [VALUE_BITS-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic [KEY_BITS-1:0]   popped_key;
        logic [VALUE_BITS-1:0] popped_value;
        logic [2:0]            status;
        logic [CW-1:0]         entry_count;
    } t_result;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_CHK,
        OP_PUSH_APP,
        OP_POP_CHK,
        OP_POP_SLOT,
        OP_POP_FIN,
        OP_RF_START,
        OP_RF_MIN,
        OP_RF_SET,
        OP_RF_DIST,
        OP_RF_APP
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    emit;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic below;
        logic full;
        logic empty;
        logic nz0;
        logic at_stop;
    } t_stat;

    // one plus the index of the highest set bit, zero when no bit is set
    function automatic logic [BW-1:0] bucket_of(input logic [KEY_BITS-1:0] d);
        logic [BW-1:0] b;
        b = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            if (d[i]) begin
                b = BW'(i + 1);
            end
        end
        return b;
    endfunction

endpackage

// ===== hdl/mrpq_datapath.sv =====
// ----------------------------------------------------------------------------
// mrpq_datapath
// Entry and bucket memories, free list, last key and the result register.
// ----------------------------------------------------------------------------
module mrpq_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mrpq_pkg::t_req   i_req,
    input  mrpq_pkg::t_cmd   i_cmd,
    output mrpq_pkg::t_stat  o_stat,
    output mrpq_pkg::t_result o_result,
    output logic             o_done
);
    import mrpq_pkg::*;

    logic [KEY_BITS-1:0]   r_key_mem  [CAPACITY];
    logic [VALUE_BITS-1:0] r_val_mem  [CAPACITY];
    logic [AW-1:0]         r_next_mem [CAPACITY];
    logic [AW-1:0]         r_head_mem [NB];
    logic [AW-1:0]         r_tail_mem [NB];

    logic [KEY_BITS-1:0]   r_q_key;
    logic [VALUE_BITS-1:0] r_q_val;
    logic [AW-1:0]         r_q_next, r_q_head, r_q_tail;

    t_req                  r_req, n_req;
    logic [KEY_BITS-1:0]   r_last, n_last, r_min, n_min;
    logic [CW-1:0]         r_total, n_total, r_fresh, n_fresh;
    logic [AW-1:0]         r_free_head, n_free_head;
    logic [NB-1:0]         r_nz, n_nz;
    logic [AW-1:0]         r_s, n_s, r_stop, n_stop, r_first, n_first, r_nx, n_nx;
    logic [BW-1:0]         r_bi, n_bi, r_b, n_b;
    logic                  r_use_free, n_use_free;
    t_result               r_res, n_res;
    logic                  r_done;

    logic                  ent_we, next_we, head_we, tail_we;
    logic [AW-1:0]         ent_raddr, ent_waddr, next_waddr, next_wdata, head_wdata;
    logic [BW-1:0]         bk_raddr, head_waddr;
    logic                  below, full, use_free, push_ok;
    logic [BW-1:0]         push_b, dist_b, pop_b;
    logic [AW-1:0]         slot;

    assign below    = r_req.push_key < r_last;
    assign full     = r_total == CW'(CAPACITY);
    assign push_ok  = !below && !full;
    // slots handed out so far minus slots held = recycled slots on the free list
    assign use_free = r_fresh != r_total;
    assign slot     = use_free ? r_free_head : r_fresh[AW-1:0];
    assign push_b   = bucket_of(r_req.push_key ^ r_last);
    assign dist_b   = bucket_of(r_q_key ^ r_last);

    // lowest nonempty bucket, bucket 0 first
    always_comb begin
        pop_b = '0;
        for (int i = NB - 1; i >= 1; i--) begin
            if (r_nz[i]) begin
                pop_b = BW'(i);
            end
        end
        if (r_nz[0]) begin
            pop_b = '0;
        end
    end

    always_comb begin
        n_req       = r_req;
        n_last      = r_last;
        n_min       = r_min;
        n_total     = r_total;
        n_fresh     = r_fresh;
        n_free_head = r_free_head;
        n_nz        = r_nz;
        n_s         = r_s;
        n_stop      = r_stop;
        n_first     = r_first;
        n_nx        = r_nx;
        n_bi        = r_bi;
        n_b         = r_b;
        n_use_free  = r_use_free;
        ent_we      = 1'b0;
        ent_waddr   = slot;
        ent_raddr   = r_s;
        next_we     = 1'b0;
        next_waddr  = r_q_tail;
        next_wdata  = r_s;
        head_we     = 1'b0;
        head_waddr  = r_b;
        head_wdata  = r_s;
        tail_we     = 1'b0;
        bk_raddr    = '0;

        unique case (i_cmd.op)
            OP_LOAD: begin
                n_req = i_req;
            end
            OP_PUSH_CHK: begin
                ent_raddr = r_free_head;
                bk_raddr  = push_b;
                if (push_ok) begin
                    ent_we     = 1'b1;
                    n_s        = slot;
                    n_b        = push_b;
                    n_use_free = use_free;
                    if (!use_free) begin
                        n_fresh = r_fresh + 1'b1;
                    end
                end
            end
            OP_PUSH_APP, OP_RF_APP: begin
                // link the slot behind the bucket tail, or start the bucket
                if (r_nz[r_b]) begin
                    next_we = 1'b1;
                end else begin
                    head_we = 1'b1;
                end
                tail_we     = 1'b1;
                n_nz[r_b]   = 1'b1;
                if (i_cmd.op == OP_PUSH_APP) begin
                    n_total = r_total + 1'b1;
                    if (r_use_free) begin
                        n_free_head = r_q_next;
                    end
                end else begin
                    n_s       = r_nx;
                    ent_raddr = r_nx;
                end
            end
            OP_POP_CHK: begin
                bk_raddr = pop_b;
                n_bi     = pop_b;
            end
            OP_POP_SLOT: begin
                n_s       = r_q_head;
                n_stop    = r_q_tail;
                ent_raddr = r_q_head;
            end
            OP_POP_FIN: begin
                if (r_s == r_stop) begin
                    n_nz[0] = 1'b0;
                end else begin
                    head_we    = 1'b1;
                    head_waddr = '0;
                    head_wdata = r_q_next;
                end
                next_we     = 1'b1;
                next_waddr  = r_s;
                next_wdata  = r_free_head;
                n_free_head = r_s;
                n_total     = r_total - 1'b1;
            end
            OP_RF_START: begin
                n_s       = r_q_head;
                n_first   = r_q_head;
                n_stop    = r_q_tail;
                n_min     = '1;
                ent_raddr = r_q_head;
            end
            OP_RF_MIN: begin
                n_min     = (r_q_key < r_min) ? r_q_key : r_min;
                n_s       = r_q_next;
                ent_raddr = r_q_next;
            end
            OP_RF_SET: begin
                n_last     = r_min;
                n_nz[r_bi] = 1'b0;
                n_s        = r_first;
                ent_raddr  = r_first;
            end
            OP_RF_DIST: begin
                n_b      = dist_b;
                n_nx     = r_q_next;
                bk_raddr = dist_b;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_res              = r_res;
        if (i_cmd.emit) begin
            n_res.popped_key   = (i_cmd.code == ST_POPPED) ? r_q_key : '0;
            n_res.popped_value = (i_cmd.code == ST_POPPED) ? r_q_val : '0;
            n_res.status       = i_cmd.code;
            n_res.entry_count  = n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_key_mem[ent_waddr] <= r_req.push_key;
            r_val_mem[ent_waddr] <= r_req.push_value;
        end
        if (next_we) begin
            r_next_mem[next_waddr] <= next_wdata;
        end
        if (head_we) begin
            r_head_mem[head_waddr] <= head_wdata;
        end
        if (tail_we) begin
            r_tail_mem[r_b] <= r_s;
        end
        r_q_key  <= r_key_mem[ent_raddr];
        r_q_val  <= r_val_mem[ent_raddr];
        r_q_next <= r_next_mem[ent_raddr];
        r_q_head <= r_head_mem[bk_raddr];
        r_q_tail <= r_tail_mem[bk_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_min      <= n_min;
        r_s        <= n_s;
        r_stop     <= n_stop;
        r_first    <= n_first;
        r_nx       <= n_nx;
        r_bi       <= n_bi;
        r_b        <= n_b;
        r_use_free <= n_use_free;
        r_res      <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_total     <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_nz        <= '0;
            r_done      <= 1'b0;
        end else begin
            r_last      <= n_last;
            r_total     <= n_total;
            r_fresh     <= n_fresh;
            r_free_head <= n_free_head;
            r_nz        <= n_nz;
            r_done      <= i_cmd.emit;
        end
    end

    assign o_stat.below   = below;
    assign o_stat.full    = full;
    assign o_stat.empty   = r_total == '0;
    assign o_stat.nz0     = r_nz[0];
    assign o_stat.at_stop = r_s == r_stop;
    assign o_result       = r_res;
    assign o_done         = r_done;

endmodule

// ===== hdl/mrpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrpq_ctrl
// Sequencer for push, pop and bucket refill.
// ----------------------------------------------------------------------------
module mrpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_pop,
    input  mrpq_pkg::t_stat i_stat,
    output mrpq_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import mrpq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_PUSH_CHK = 11'b000_0000_0010,
        S_PUSH_APP = 11'b000_0000_0100,
        S_POP_CHK  = 11'b000_0000_1000,
        S_POP_SLOT = 11'b000_0001_0000,
        S_POP_FIN  = 11'b000_0010_0000,
        S_RF_START = 11'b000_0100_0000,
        S_RF_MIN   = 11'b000_1000_0000,
        S_RF_SET   = 11'b001_0000_0000,
        S_RF_DIST  = 11'b010_0000_0000,
        S_RF_APP   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.emit  = 1'b0;
        o_cmd.code  = ST_PUSHED;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_pop ? S_POP_CHK : S_PUSH_CHK;
                end
            end
            S_PUSH_CHK: begin
                o_cmd.op = OP_PUSH_CHK;
                priority if (i_stat.below) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_BELOW;
                    n_state    = S_IDLE;
                end else if (i_stat.full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_FULL;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_PUSH_APP;
                end
            end
            S_PUSH_APP: begin
                o_cmd.op   = OP_PUSH_APP;
                o_cmd.emit = 1'b1;
                o_cmd.code = ST_PUSHED;
                n_state    = S_IDLE;
            end
            S_POP_CHK: begin
                o_cmd.op = OP_POP_CHK;
                priority if (i_stat.empty) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_EMPTY;
                    n_state    = S_IDLE;
                end else if (i_stat.nz0) begin
                    n_state = S_POP_SLOT;
                end else begin
                    n_state = S_RF_START;
                end
            end
            S_POP_SLOT: begin
                o_cmd.op = OP_POP_SLOT;
                n_state  = S_POP_FIN;
            end
            S_POP_FIN: begin
                o_cmd.op   = OP_POP_FIN;
                o_cmd.emit = 1'b1;
                o_cmd.code = ST_POPPED;
                n_state    = S_IDLE;
            end
            S_RF_START: begin
                o_cmd.op = OP_RF_START;
                n_state  = S_RF_MIN;
            end
            S_RF_MIN: begin
                o_cmd.op = OP_RF_MIN;
                if (i_stat.at_stop) begin
                    n_state = S_RF_SET;
                end
            end
            S_RF_SET: begin
                o_cmd.op = OP_RF_SET;
                n_state  = S_RF_DIST;
            end
            S_RF_DIST: begin
                o_cmd.op = OP_RF_DIST;
                n_state  = S_RF_APP;
            end
            S_RF_APP: begin
                o_cmd.op = OP_RF_APP;
                // bucket 0 now holds the minimum, so the pop starts over
                n_state  = i_stat.at_stop ? S_POP_CHK : S_RF_DIST;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

// ===== hdl/monotone_radix_priority_queue.sv =====
// ----------------------------------------------------------------------------
// monotone_radix_priority_queue
// Monotone min-priority queue of key and value pairs held in radix buckets.
// ----------------------------------------------------------------------------
// A request transfers on i_req when start is high and busy is low: a push of
// push_key and push_value, or a pop of the minimum entry. Each request gives
// exactly one result on o_result, valid for the single cycle in which o_done
// is high; the receiver cannot hold it off.
// A push shows its result after its check and append states, and busy drops
// with it, so a new request is taken only once the last one is through. A
// refused push or a pop on an empty queue shows its result after the check
// state alone. A pop served from bucket 0 shows its result after its check,
// slot and finish states. When bucket 0 is empty, the pop first refills it
// from the lowest nonempty bucket: one pass to find the minimum and one to
// refile every entry, both limited by the single read port of the entry
// memories.
// Reset empties the queue and sets the last key to zero; no clearing pass is
// needed, the free list grows from a count of slots handed out.
// ----------------------------------------------------------------------------
module monotone_radix_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mrpq_pkg::t_req    i_req,
    output mrpq_pkg::t_result o_result,
    output logic              o_done
);
    import mrpq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mrpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_pop   (i_req.req_type == REQ_POP),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mrpq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule
